@@ hdl/complex_arithmetic_unit_top_defines.svh @@
// Assertion macros shared by the checker of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define CAU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex arithmetic unit check failed");

// Plain condition checked at every rising edge outside reset.
`define CAU_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("complex arithmetic unit check failed");

`endif

@@ hdl/cau_pkg.sv @@
// Types, constants and the saturation function of the complex arithmetic unit.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = 2 * WORD_BITS + 1;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_EQ  = 3'd4;
  localparam logic [2:0] CMD_NE  = 3'd5;

  typedef enum logic [2:0] {
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_CMP,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic                        truth;
    logic                        div_zero;
    logic                        overflow;
  } cau_out_t;

  typedef struct packed {
    kind_t                       kind;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
    logic                        truth;
    logic                        div_zero;
  } cau_item_t;

  typedef struct packed {
    logic                 ovf;
    logic [WORD_BITS-1:0] w;
  } sat_t;

  function automatic sat_t sat_word(input logic neg, input logic [SUM_BITS-1:0] mag);
    sat_t                r;
    logic [SUM_BITS-1:0] lim;
    logic [SUM_BITS-1:0] nm;
    lim   = SUM_BITS'(1) << (WORD_BITS - 1);
    nm    = -mag;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        r.ovf = 1'b1;
        r.w   = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
        r.w = nm[WORD_BITS-1:0];
      end
    end else begin
      if (mag >= lim) begin
        r.ovf = 1'b1;
        r.w   = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else begin
        r.w = mag[WORD_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/cau_front.sv @@
// Front end: takes commands, classifies them and resolves compares and division by zero.
module cau_front import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cau_in_t   operands,
  input  logic      full,
  output logic      push,
  output cau_item_t item
);

  logic      item_valid;
  logic      accept;
  logic      eq;
  cau_item_t item_next;

  assign busy   = item_valid && full;
  assign push   = item_valid && !full;
  assign accept = start && !busy;
  assign eq     = (operands.a_re == operands.b_re) && (operands.a_im == operands.b_im);

  always_comb begin
    item_next.a_re     = operands.a_re;
    item_next.a_im     = operands.a_im;
    item_next.b_re     = operands.b_re;
    item_next.b_im     = operands.b_im;
    item_next.truth    = 1'b0;
    item_next.div_zero = 1'b0;
    case (operands.cmd)
      CMD_ADD: item_next.kind = K_ADD;
      CMD_SUB: item_next.kind = K_SUB;
      CMD_MUL: item_next.kind = K_MUL;
      CMD_DIV: begin
        item_next.kind     = K_DIV;
        item_next.div_zero = (operands.b_re == '0) && (operands.b_im == '0);
      end
      CMD_EQ: begin
        item_next.kind  = K_CMP;
        item_next.truth = eq;
      end
      CMD_NE: begin
        item_next.kind  = K_CMP;
        item_next.truth = !eq;
      end
      default: item_next.kind = K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

@@ hdl/cau_queue.sv @@
// Short queue of classified commands between the front end and the back end.
module cau_queue import cau_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cau_item_t push_data,
  output logic      full,
  input  logic      pop,
  output cau_item_t pop_data,
  output logic      empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cau_item_t             slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hdl/cau_back.sv @@
// Back end: pipelined products, rounding, restoring divider stages and saturation.
module cau_back import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  cau_item_t pop_data,
  output logic      pop,
  output logic      done,
  output cau_out_t  result
);

  localparam int NUM_BITS = SUM_BITS + FRAC_BITS;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic                 truth;
    logic                 div_zero;
    logic                 ovf;
    logic [WORD_BITS-1:0] w_re;
    logic [WORD_BITS-1:0] w_im;
    logic                 neg_re;
    logic                 neg_im;
    logic                 big_re;
    logic                 big_im;
    logic [PROD_BITS-1:0] rem_re;
    logic [PROD_BITS-1:0] rem_im;
    logic [WORD_BITS-1:0] low_re;
    logic [WORD_BITS-1:0] low_im;
    logic [WORD_BITS-1:0] q_re;
    logic [WORD_BITS-1:0] q_im;
    logic [PROD_BITS-1:0] den;
  } div_stage_t;

  assign pop = !empty;

  // Stage one: products and plain sums or differences.
  logic                        s1_valid;
  kind_t                       s1_kind;
  logic                        s1_truth;
  logic                        s1_dz;
  logic signed [PROD_BITS-1:0] s1_ac, s1_bd, s1_bc, s1_ad, s1_cc, s1_dd;
  logic signed [WORD_BITS:0]   s1_sre, s1_sim;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind  <= pop_data.kind;
    s1_truth <= pop_data.truth;
    s1_dz    <= pop_data.div_zero;
    s1_ac    <= pop_data.a_re * pop_data.b_re;
    s1_bd    <= pop_data.a_im * pop_data.b_im;
    s1_bc    <= pop_data.a_im * pop_data.b_re;
    s1_ad    <= pop_data.a_re * pop_data.b_im;
    s1_cc    <= pop_data.b_re * pop_data.b_re;
    s1_dd    <= pop_data.b_im * pop_data.b_im;
    if (pop_data.kind == K_SUB) begin
      s1_sre <= pop_data.a_re - pop_data.b_re;
      s1_sim <= pop_data.a_im - pop_data.b_im;
    end else begin
      s1_sre <= pop_data.a_re + pop_data.b_re;
      s1_sim <= pop_data.a_im + pop_data.b_im;
    end
  end

  // Stage two: exact sums of products and the divisor.
  logic                       s2_valid;
  kind_t                      s2_kind;
  logic                       s2_truth;
  logic                       s2_dz;
  logic signed [SUM_BITS-1:0] s2_re, s2_im;
  logic [PROD_BITS-1:0]       s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind  <= s1_kind;
    s2_truth <= s1_truth;
    s2_dz    <= s1_dz;
    s2_den   <= $unsigned(s1_cc) + $unsigned(s1_dd);
    case (s1_kind)
      K_MUL: begin
        s2_re <= SUM_BITS'(s1_ac) - SUM_BITS'(s1_bd);
        s2_im <= SUM_BITS'(s1_bc) + SUM_BITS'(s1_ad);
      end
      K_DIV: begin
        s2_re <= SUM_BITS'(s1_ac) + SUM_BITS'(s1_bd);
        s2_im <= SUM_BITS'(s1_bc) - SUM_BITS'(s1_ad);
      end
      default: begin
        s2_re <= SUM_BITS'(s1_sre);
        s2_im <= SUM_BITS'(s1_sim);
      end
    endcase
  end

  // Stage three: sign and magnitude, rounding, saturation of sums and products, and divider set-up.
  div_stage_t stages [WORD_BITS+1];
  div_stage_t s3_next;

  always_comb begin
    logic                neg_re, neg_im;
    logic [SUM_BITS-1:0] mag_re, mag_im, rnd_re, rnd_im;
    logic [NUM_BITS-1:0] num_re, num_im;
    sat_t                sr, si;
    neg_re = s2_re[SUM_BITS-1];
    neg_im = s2_im[SUM_BITS-1];
    mag_re = neg_re ? $unsigned(-s2_re) : $unsigned(s2_re);
    mag_im = neg_im ? $unsigned(-s2_im) : $unsigned(s2_im);
    rnd_re = (mag_re + (SUM_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd_im = (mag_im + (SUM_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    num_re = {mag_re, {FRAC_BITS{1'b0}}};
    num_im = {mag_im, {FRAC_BITS{1'b0}}};
    if (s2_kind == K_MUL) begin
      sr = sat_word(neg_re, rnd_re);
      si = sat_word(neg_im, rnd_im);
    end else begin
      sr = sat_word(neg_re, mag_re);
      si = sat_word(neg_im, mag_im);
    end
    s3_next.valid    = s2_valid;
    s3_next.kind     = s2_kind;
    s3_next.truth    = s2_truth;
    s3_next.div_zero = s2_dz;
    s3_next.neg_re   = neg_re;
    s3_next.neg_im   = neg_im;
    s3_next.big_re   = num_re[NUM_BITS-1:WORD_BITS] >= s2_den;
    s3_next.big_im   = num_im[NUM_BITS-1:WORD_BITS] >= s2_den;
    s3_next.rem_re   = PROD_BITS'(num_re[NUM_BITS-1:WORD_BITS]);
    s3_next.rem_im   = PROD_BITS'(num_im[NUM_BITS-1:WORD_BITS]);
    s3_next.low_re   = num_re[WORD_BITS-1:0];
    s3_next.low_im   = num_im[WORD_BITS-1:0];
    s3_next.q_re     = '0;
    s3_next.q_im     = '0;
    s3_next.den      = s2_den;
    case (s2_kind)
      K_ADD, K_SUB, K_MUL: begin
        s3_next.ovf  = sr.ovf || si.ovf;
        s3_next.w_re = sr.w;
        s3_next.w_im = si.w;
      end
      default: begin
        s3_next.ovf  = 1'b0;
        s3_next.w_re = '0;
        s3_next.w_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stages[0].valid <= 1'b0;
    end else begin
      stages[0].valid <= s3_next.valid;
    end
    stages[0].kind     <= s3_next.kind;
    stages[0].truth    <= s3_next.truth;
    stages[0].div_zero <= s3_next.div_zero;
    stages[0].ovf      <= s3_next.ovf;
    stages[0].w_re     <= s3_next.w_re;
    stages[0].w_im     <= s3_next.w_im;
    stages[0].neg_re   <= s3_next.neg_re;
    stages[0].neg_im   <= s3_next.neg_im;
    stages[0].big_re   <= s3_next.big_re;
    stages[0].big_im   <= s3_next.big_im;
    stages[0].rem_re   <= s3_next.rem_re;
    stages[0].rem_im   <= s3_next.rem_im;
    stages[0].low_re   <= s3_next.low_re;
    stages[0].low_im   <= s3_next.low_im;
    stages[0].q_re     <= s3_next.q_re;
    stages[0].q_im     <= s3_next.q_im;
    stages[0].den      <= s3_next.den;
  end

  // Restoring divider: one quotient bit of each part per stage.
  for (genvar k = 0; k < WORD_BITS; k++) begin : g_div
    div_stage_t nxt;

    always_comb begin
      logic [PROD_BITS:0] t_re, t_im, d_re, d_im;
      logic               ge_re, ge_im;
      nxt    = stages[k];
      t_re   = {stages[k].rem_re, stages[k].low_re[WORD_BITS-1]};
      t_im   = {stages[k].rem_im, stages[k].low_im[WORD_BITS-1]};
      ge_re  = t_re >= {1'b0, stages[k].den};
      ge_im  = t_im >= {1'b0, stages[k].den};
      d_re   = ge_re ? t_re - {1'b0, stages[k].den} : t_re;
      d_im   = ge_im ? t_im - {1'b0, stages[k].den} : t_im;
      nxt.rem_re = d_re[PROD_BITS-1:0];
      nxt.rem_im = d_im[PROD_BITS-1:0];
      nxt.low_re = {stages[k].low_re[WORD_BITS-2:0], 1'b0};
      nxt.low_im = {stages[k].low_im[WORD_BITS-2:0], 1'b0};
      nxt.q_re   = {stages[k].q_re[WORD_BITS-2:0], ge_re};
      nxt.q_im   = {stages[k].q_im[WORD_BITS-2:0], ge_im};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stages[k+1].valid <= 1'b0;
      end else begin
        stages[k+1].valid <= nxt.valid;
      end
      stages[k+1].kind     <= nxt.kind;
      stages[k+1].truth    <= nxt.truth;
      stages[k+1].div_zero <= nxt.div_zero;
      stages[k+1].ovf      <= nxt.ovf;
      stages[k+1].w_re     <= nxt.w_re;
      stages[k+1].w_im     <= nxt.w_im;
      stages[k+1].neg_re   <= nxt.neg_re;
      stages[k+1].neg_im   <= nxt.neg_im;
      stages[k+1].big_re   <= nxt.big_re;
      stages[k+1].big_im   <= nxt.big_im;
      stages[k+1].rem_re   <= nxt.rem_re;
      stages[k+1].rem_im   <= nxt.rem_im;
      stages[k+1].low_re   <= nxt.low_re;
      stages[k+1].low_im   <= nxt.low_im;
      stages[k+1].q_re     <= nxt.q_re;
      stages[k+1].q_im     <= nxt.q_im;
      stages[k+1].den      <= nxt.den;
    end
  end

  // Final stage: quotient saturation and result assembly.
  div_stage_t fin;
  cau_out_t   result_next;

  assign fin = stages[WORD_BITS];

  always_comb begin
    sat_t                qr, qi;
    logic [SUM_BITS-1:0] m_re, m_im;
    m_re = fin.big_re ? {SUM_BITS{1'b1}} : SUM_BITS'(fin.q_re);
    m_im = fin.big_im ? {SUM_BITS{1'b1}} : SUM_BITS'(fin.q_im);
    qr   = sat_word(fin.neg_re, m_re);
    qi   = sat_word(fin.neg_im, m_im);
    result_next.truth    = fin.truth;
    result_next.div_zero = fin.div_zero;
    if (fin.kind == K_DIV) begin
      if (fin.div_zero) begin
        result_next.res_re   = '0;
        result_next.res_im   = '0;
        result_next.overflow = 1'b0;
      end else begin
        result_next.res_re   = qr.w;
        result_next.res_im   = qi.w;
        result_next.overflow = qr.ovf || qi.ovf;
      end
    end else begin
      result_next.res_re   = fin.w_re;
      result_next.res_im   = fin.w_im;
      result_next.overflow = fin.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ hdl/complex_arithmetic_unit_top.sv @@
// Top level of the complex arithmetic unit.
// A command transfer takes place at a rising edge with start high and busy low; operands
// carries the opcode and the two complex operands a and b in signed Q16.16.
// Opcodes give add, subtract, multiply, divide, equal and not equal; arithmetic parts
// saturate, compares return truth, and a divide by zero returns div_zero with a zero result.
// Each result transfer is shown on result for exactly one cycle with done high.
// The result of a command passes through one front register, one
// queue slot, three arithmetic stages, 32 divider stages and the output register.
// Every operation runs through the same pipeline, so one command is taken every cycle
// and results leave in command order.
// The receiver cannot stall; the back end drains the queue every cycle, so busy stays low
// in operation.
// Reset empties the front register, the queue and every pipeline stage.
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cau_in_t  operands,
  output logic     done,
  output cau_out_t result
);

  logic      full;
  logic      push;
  logic      pop;
  logic      empty;
  cau_item_t push_data;
  cau_item_t pop_data;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .full     (full),
    .push     (push),
    .item     (push_data)
  );

  cau_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .done     (done),
    .result   (result)
  );

endmodule

@@ hdl/cau_checker.sv @@
// Port checker of the complex arithmetic unit and its binding to the top level.
`include "complex_arithmetic_unit_top_defines.svh"

module cau_port_checker import cau_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input cau_out_t result
);

  localparam int LATENCY = WORD_BITS + 6;

  logic parts_clear;

  assign parts_clear = (result.res_re == '0) && (result.res_im == '0) && !result.overflow;

  `CAU_ASSERT_IMPLY(a_done_follows_cmd, clk, rst, done, $past(start && !busy, LATENCY))
  `CAU_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)
  `CAU_ASSERT_IMPLY(a_dz_clean, clk, rst, done && result.div_zero, parts_clear && !result.truth)
  `CAU_ASSERT_IMPLY(a_truth_clean, clk, rst, done && result.truth, parts_clear)

endmodule

bind complex_arithmetic_unit_top cau_port_checker u_cau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
